// File: rtl/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Page refresh command bytes
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_PULL  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       frame_last;
  } res_t;

endpackage

// File: rtl/page_framebuffer_pixel_engine.sv
`timescale 1ns / 1ps

// Monochrome page-organised frame store with panel refresh stream.
// Slave channel (s_*) carries drawing transactions: s_tuser selects set pixel,
// fill rectangle, clear store or pull next refresh byte; s_tdata carries the
// coordinates and colour. Master channel (m_*) returns one byte per pull:
// page command bytes (m_tuser high) and column data, m_tlast on the frame's
// final byte. Set, fill and clear return nothing.
// Work per transaction, set by the read-modify-write of the single store:
//   set pixel: one byte read and then written, nothing when off screen;
//   fill: a read and a write per byte touched (columns x bands), none if none is hit;
//   clear: all COLUMNS*PAGES store entries zeroed, one store entry per cycle;
//   pull: a store read for column data, then a load into the output register.
// Reset runs a clearing pass over all COLUMNS*PAGES entries with s_tready low, and
// sets the refresh pointer to the start of the frame.
// The output register holds a result until m_tready takes it; drawing goes on
// meanwhile, and a pull waits only while the register is still full.
module page_framebuffer_pixel_engine #(
  parameter int COLUMNS = pfe_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfe_pkg::PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // x_start, y_start, x_end, y_end, color, zero fill
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte
  output logic        m_tuser,  // is_command
  output logic        m_tlast   // frame_last
);

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              out_free;
  logic              res_load;
  pfe_pkg::res_t     res;

  pfe_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfe_ctrl #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  // Register is free when empty or emptied this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= res.out_byte;
      m_tuser <= res.is_command;
      m_tlast <= res.frame_last;
    end
  end

endmodule

// File: rtl/pfe_store.sv
`timescale 1ns / 1ps

module pfe_store #(
  parameter int DEPTH  = pfe_pkg::COLUMNS_DEF * pfe_pkg::PAGES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pfe_ctrl.sv
`timescale 1ns / 1ps

module pfe_ctrl #(
  parameter int COLUMNS = pfe_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfe_pkg::PAGES_DEF,
  parameter int DEPTH   = COLUMNS * PAGES,
  parameter int ADDR_W  = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  input  logic              out_free,
  output logic              res_load,
  output pfe_pkg::res_t     res
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OFF_W  = $clog2(COLUMNS + 3);
  localparam int ROWS   = 8 * PAGES;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_FILL_RD = 5'b00100,
    ST_FILL_WR = 5'b01000,
    ST_PULL    = 5'b10000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] swp;
  logic [COL_W-1:0]  f_x, f_xs, f_xe;
  logic [PAGE_W-1:0] f_band, f_band_first, f_band_end;
  logic [2:0]        f_ylo, f_yhi;
  logic              f_color;
  logic [7:0]        f_mask;
  logic [ADDR_W-1:0] f_addr;
  logic [PAGE_W-1:0] r_page;
  logic [OFF_W-1:0]  r_off;
  logic              p_cmd;
  logic [7:0]        p_byte;
  logic              p_last;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                                input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(page) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

  // Row k of a band maps to bit 7-k
  function automatic logic [7:0] band_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (3'(k) >= lo && 3'(k) <= hi) begin
        m[7-k] = 1'b1;
      end
    end
    return m;
  endfunction

  // Input fields
  pfe_pkg::kind_t kind;
  logic [7:0] xs, ys, xe_in, ye_in;
  logic       color;
  logic [8:0] xe_c, ye_c;
  logic       draw_ok;
  logic       accept;

  assign kind    = pfe_pkg::kind_t'(s_tuser);
  assign xs      = s_tdata[7:0];
  assign ys      = s_tdata[15:8];
  assign xe_in   = (kind == pfe_pkg::KIND_SET) ? xs : s_tdata[23:16];
  assign ye_in   = (kind == pfe_pkg::KIND_SET) ? ys : s_tdata[31:24];
  assign color   = s_tdata[32];
  assign xe_c    = ({1'b0, xe_in} > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : {1'b0, xe_in};
  assign ye_c    = ({1'b0, ye_in} > 9'(ROWS - 1)) ? 9'(ROWS - 1) : {1'b0, ye_in};
  // Reversed or wholly off-screen shapes fail here
  assign draw_ok = ({1'b0, xs} <= xe_c) && ({1'b0, ys} <= ye_c);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Fill walk
  logic [7:0]        cur_mask;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pull_addr;
  logic              pull_cmd;

  assign cur_mask  = band_mask((f_band == f_band_first) ? f_ylo : 3'd0,
                               (f_band == f_band_end) ? f_yhi : 3'd7);
  assign cur_addr  = addr_of(PAGE_W'(PAGES - 1) - f_band, f_x);
  assign pull_cmd  = (r_off < OFF_W'(3));
  assign pull_addr = addr_of(r_page, COL_W'(r_off - OFF_W'(3)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = f_addr;
    wr_data = (rd_data & ~f_mask) | (f_color ? f_mask : 8'h00);
    rd_en   = 1'b0;
    rd_addr = cur_addr;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = swp;
        wr_data = 8'h00;
      end
      ST_FILL_RD: begin
        rd_en = 1'b1;
      end
      ST_FILL_WR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        rd_en   = accept && (kind == pfe_pkg::KIND_PULL) && !pull_cmd;
        rd_addr = pull_addr;
      end
      ST_PULL: begin
      end
      default: begin
      end
    endcase
  end

  assign res_load       = (state == ST_PULL) && out_free;
  assign res.out_byte   = p_cmd ? p_byte : rd_data;
  assign res.is_command = p_cmd;
  assign res.frame_last = p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      swp    <= '0;
      r_page <= '0;
      r_off  <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          swp <= swp + 1'b1;
          if (swp == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              pfe_pkg::KIND_SET, pfe_pkg::KIND_FILL: begin
                if (draw_ok) begin
                  state <= ST_FILL_RD;
                end
              end
              pfe_pkg::KIND_CLEAR: begin
                swp   <= '0;
                state <= ST_CLEAR;
              end
              pfe_pkg::KIND_PULL: begin
                state <= ST_PULL;
                // Advance the frame pointer, wrapping after the last byte
                if (r_off == OFF_W'(COLUMNS + 2)) begin
                  r_off <= '0;
                  if (r_page == PAGE_W'(PAGES - 1)) begin
                    r_page <= '0;
                  end else begin
                    r_page <= r_page + 1'b1;
                  end
                end else begin
                  r_off <= r_off + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL_RD: begin
          state <= ST_FILL_WR;
        end
        ST_FILL_WR: begin
          if (f_x == f_xe) begin
            if (f_band == f_band_end) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_FILL_RD;
            end
          end else begin
            state <= ST_FILL_RD;
          end
        end
        ST_PULL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      f_x          <= xs[COL_W-1:0];
      f_xs         <= xs[COL_W-1:0];
      f_xe         <= xe_c[COL_W-1:0];
      f_band       <= ys[3 +: PAGE_W];
      f_band_first <= ys[3 +: PAGE_W];
      f_band_end   <= ye_c[3 +: PAGE_W];
      f_ylo        <= ys[2:0];
      f_yhi        <= ye_c[2:0];
      f_color      <= color;
      p_cmd        <= pull_cmd;
      p_last       <= (r_page == PAGE_W'(PAGES - 1)) && (r_off == OFF_W'(COLUMNS + 2));
      if (r_off == OFF_W'(0)) begin
        p_byte <= pfe_pkg::CMD_PAGE + 8'(r_page);
      end else if (r_off == OFF_W'(1)) begin
        p_byte <= pfe_pkg::CMD_COL_LO;
      end else begin
        p_byte <= pfe_pkg::CMD_COL_HI;
      end
    end
    if (state == ST_FILL_RD) begin
      f_mask <= cur_mask;
      f_addr <= cur_addr;
    end
    if (state == ST_FILL_WR) begin
      if (f_x == f_xe) begin
        f_x    <= f_xs;
        f_band <= f_band + 1'b1;
      end else begin
        f_x <= f_x + 1'b1;
      end
    end
  end

endmodule
